FILE: rtl/core/mciir_pkg.sv
// Shared types, constants and register indexes of the multichannel IIR bandpass.
`default_nettype none
package mciir_pkg;

  localparam int DataW      = 16;
  localparam int AccW       = 32;
  localparam int ChanW      = 3;
  localparam int CfgIdxW    = 3;
  localparam int DefChannels = 8;
  localparam int DefFracBits = 14;

  typedef enum logic [CfgIdxW-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_e;

  localparam logic signed [DataW-1:0] CoefB0Rst = 16'sd969;
  localparam logic signed [DataW-1:0] CoefB1Rst = 16'sd0;
  localparam logic signed [DataW-1:0] CoefB2Rst = -16'sd969;
  localparam logic signed [DataW-1:0] CoefA1Rst = -16'sd21145;
  localparam logic signed [DataW-1:0] CoefA2Rst = 16'sd14444;

  typedef struct packed {
    logic signed [DataW-1:0] b0;
    logic signed [DataW-1:0] b1;
    logic signed [DataW-1:0] b2;
    logic signed [DataW-1:0] a1;
    logic signed [DataW-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [DataW-1:0] x1;
    logic signed [DataW-1:0] x2;
    logic signed [DataW-1:0] y1;
    logic signed [DataW-1:0] y2;
  } hist_t;

endpackage
`default_nettype wire

FILE: rtl/core/mciir_cfg.sv
// Coefficient register file written through the configuration channel.
`default_nettype none
module mciir_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mciir_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [mciir_pkg::DataW-1:0]     cfg_data_i,
  output mciir_pkg::coef_t                     coef_o
);
  import mciir_pkg::*;

  coef_t coef_q, coef_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_B0:  coef_d.b0 = cfg_data_i;
        REG_B1:  coef_d.b1 = cfg_data_i;
        REG_B2:  coef_d.b2 = cfg_data_i;
        REG_A1:  coef_d.a1 = cfg_data_i;
        REG_A2:  coef_d.a2 = cfg_data_i;
        default: coef_d = coef_q; // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= CoefB0Rst;
      coef_q.b1 <= CoefB1Rst;
      coef_q.b2 <= CoefB2Rst;
      coef_q.a1 <= CoefA1Rst;
      coef_q.a2 <= CoefA2Rst;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

FILE: rtl/core/mciir_hist.sv
// Per-channel filter history: last two inputs and last two outputs.
`default_nettype none
module mciir_hist #(
  parameter int Channels = mciir_pkg::DefChannels,
  parameter int IdxW     = (Channels > 1) ? $clog2(Channels) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [IdxW-1:0]               idx_i,
  input  wire logic                          we_i,
  input  wire logic [mciir_pkg::DataW-1:0]   x0_i,
  input  wire logic [mciir_pkg::DataW-1:0]   y0_i,
  output mciir_pkg::hist_t                   hist_o
);
  import mciir_pkg::*;

  logic [DataW-1:0] x1_q [Channels];
  logic [DataW-1:0] x2_q [Channels];
  logic [DataW-1:0] y1_q [Channels];
  logic [DataW-1:0] y2_q [Channels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (we_i) begin
      // advance the channel's history by one sample
      x2_q[idx_i] <= x1_q[idx_i];
      x1_q[idx_i] <= x0_i;
      y2_q[idx_i] <= y1_q[idx_i];
      y1_q[idx_i] <= y0_i;
    end
  end

  always_comb begin
    hist_o.x1 = x1_q[idx_i];
    hist_o.x2 = x2_q[idx_i];
    hist_o.y1 = y1_q[idx_i];
    hist_o.y2 = y2_q[idx_i];
  end

`ifndef SYNTH
  a_hist_y1_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |=> y1_q[$past(idx_i)] == $past(y0_i))
    else $error("output history not updated");
  a_hist_x2_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |=> x2_q[$past(idx_i)] == $past(hist_o.x1))
    else $error("input history did not shift");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/mciir_mac.sv
// Five signed 16x16 products, wrapping 32-bit sum and arithmetic shift.
`default_nettype none
module mciir_mac #(
  parameter int FracBits = mciir_pkg::DefFracBits
) (
  input  mciir_pkg::coef_t                   coef_i,
  input  mciir_pkg::hist_t                   hist_i,
  input  wire logic [mciir_pkg::DataW-1:0]   x0_i,
  output logic [mciir_pkg::DataW-1:0]        y0_o
);
  import mciir_pkg::*;

  logic signed [DataW-1:0] na1, na2, x0;
  logic signed [AccW-1:0]  p0, p1, p2, p3, p4, acc, shifted;

  always_comb begin
    // feedback terms negate in 16 bits and wrap
    na1 = DataW'(-coef_i.a1);
    na2 = DataW'(-coef_i.a2);
    x0  = $signed(x0_i);
    p0  = AccW'(coef_i.b0 * x0);
    p1  = AccW'(coef_i.b1 * hist_i.x1);
    p2  = AccW'(coef_i.b2 * hist_i.x2);
    p3  = AccW'(na1 * hist_i.y1);
    p4  = AccW'(na2 * hist_i.y2);
    acc = p0 + p1 + p2 + p3 + p4;
    shifted = acc >>> FracBits;
    y0_o = shifted[DataW-1:0];
  end

endmodule
`default_nettype wire

FILE: rtl/core/multichannel_iir_bandpass.sv
// Top level of the multichannel direct-form-1 biquad bandpass filter.
// Usage:
//   Input stream: s_axis_tuser carries the channel number (3 bits), s_axis_tdata the
//   signed 16-bit sample. Output stream: m_axis_tdata carries the filtered sample,
//   m_axis_tuser the channel it belongs to. Each channel keeps its own history.
//   Configuration channel: cfg_index_i selects b0, b1, b2, a1, a2 (0..4), cfg_data_i
//   holds the signed Q(FRAC_BITS) value; writes to other indexes are dropped. Write
//   coefficients only while no request is in flight.
//   Path: a taken request sits in the input register; its result, formed by the products
//   and sum, is loaded into the output register. Throughput: one request per cycle while
//   m_axis_tready keeps the output moving, set by the single multiply-accumulate pass;
//   back-to-back requests on one channel see the history written by the previous one.
//   Stall: while m_axis_tready is low the result holds; one more request is taken into
//   the input register, then s_axis_tready drops until the output is drained.
//   Reset: clears all channel histories to zero and loads the default coefficients.
`default_nettype none
module multichannel_iir_bandpass #(
  parameter int CHANNELS  = mciir_pkg::DefChannels,
  parameter int FRAC_BITS = mciir_pkg::DefFracBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // [15:0] sample
  input  wire logic [mciir_pkg::ChanW-1:0]   s_axis_tuser,  // [2:0] channel
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [15:0]                        m_axis_tdata,  // [15:0] filtered
  output logic [mciir_pkg::ChanW-1:0]        m_axis_tuser,  // [2:0] out_channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mciir_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [mciir_pkg::DataW-1:0]   cfg_data_i
);
  import mciir_pkg::*;

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic              s0_valid_q;
  logic [ChanW-1:0]  s0_ch_q;
  logic [DataW-1:0]  s0_sample_q;
  logic              m_valid_q;
  logic [ChanW-1:0]  m_ch_q;
  logic [DataW-1:0]  m_data_q;

  logic              adv, fire, take;
  logic [IdxW-1:0]   idx;
  logic [DataW-1:0]  y0;
  coef_t             coef;
  hist_t             hist;

  assign adv  = !m_valid_q || m_axis_tready;
  assign fire = s0_valid_q && adv;
  assign s_axis_tready = !s0_valid_q || adv;
  assign take = s_axis_tvalid && s_axis_tready;

  // fold channel numbers past CHANNELS onto the slots below
  always_comb begin
    idx = '0;
    for (int k = 0; k < (1 << ChanW); k++) begin
      if (s0_ch_q == ChanW'(k)) begin
        idx = IdxW'(k % CHANNELS);
      end
    end
  end

  mciir_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  mciir_hist #(
    .Channels (CHANNELS),
    .IdxW     (IdxW)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (idx),
    .we_i   (fire),
    .x0_i   (s0_sample_q),
    .y0_i   (y0),
    .hist_o (hist)
  );

  mciir_mac #(
    .FracBits (FRAC_BITS)
  ) u_mac (
    .coef_i (coef),
    .hist_i (hist),
    .x0_i   (s0_sample_q),
    .y0_o   (y0)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s0_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        m_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s0_ch_q     <= s_axis_tuser;
      s0_sample_q <= s_axis_tdata;
    end
    if (fire) begin
      m_ch_q   <= s0_ch_q;
      m_data_q <= y0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_ch_q;

`ifndef SYNTH
  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_valid_q && m_ch_q == $past(s0_ch_q) && m_data_q == $past(y0))
    else $error("result register not loaded from input stage");
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s0_valid_q && m_valid_q && !m_axis_tready)
    else $error("input stalled with room in the pipe");
  a_take_to_s0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> s0_valid_q && s0_ch_q == $past(s_axis_tuser)
      && s0_sample_q == $past(s_axis_tdata))
    else $error("accepted request not captured");
`endif

endmodule
`default_nettype wire
